### hdl/l1dmp_pkg.sv
// ----------------------------------------------------------------------------
// L1 distance matrix product package
// Shared constants, codes and control structures of the block.
// ----------------------------------------------------------------------------
package l1dmp_pkg;

    // Default dimensions and element width of the stores.
    localparam int MAX_ROWS_DEF      = 64;
    localparam int MAX_COLS_DEF      = 64;
    localparam int MAX_DEPTH_DEF     = 64;
    localparam int ELEMENT_WIDTH_DEF = 16;

    // Fixed field widths of the streams and the configuration port.
    localparam int RESULT_WIDTH = 23;
    localparam int IDX_W        = 6;
    localparam int VALUE_W      = 16;
    localparam int FUNC_W       = 2;
    localparam int REG_W        = 7;
    localparam int CFG_IDX_W    = 2;

    // Clamped dimensions stay below 128 and are held in nine bits.
    localparam int DIM_W = 9;

    // Input function codes.
    localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_C    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd3;

    // Operating modes.
    localparam logic [1:0] MODE_FORWARD = 2'd0;
    localparam logic [1:0] MODE_GRAD_A  = 2'd1;
    localparam logic [1:0] MODE_GRAD_B  = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd3;

    // Configuration reset values.
    localparam logic [1:0]       MODE_RST = MODE_FORWARD;
    localparam logic [REG_W-1:0] DIM_RST  = 7'd64;

    // Effective configuration seen by the controller and the datapath.
    typedef struct packed {
        logic [1:0]       mode;
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nc;
        logic [DIM_W-1:0] nd;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic wr_c;
        logic start;
        logic issue;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic k_last;
        logic out_free;
    } status_t;

endpackage

### hdl/l1_distance_matrix_product.sv
// ----------------------------------------------------------------------------
// L1 distance matrix product
// An element write, or a compute request that gives no result, is taken in the
// idle state. A compute request over d terms walks the terms, drains and then
// hands its sum to the result register (straight away when d is zero); the
// hand-off waits while the result register still holds an unaccepted result.
// Reset clears the controller, the handshake flags and the configuration;
// the element stores are not cleared and hold nothing until written.
// ----------------------------------------------------------------------------
module l1_distance_matrix_product #(
    parameter int MAX_ROWS      = l1dmp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = l1dmp_pkg::MAX_COLS_DEF,
    parameter int MAX_DEPTH     = l1dmp_pkg::MAX_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = l1dmp_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [l1dmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [l1dmp_pkg::REG_W-1:0]         cfg_wdata,

    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // row[5:0], col[11:6], value[27:12]
    input  logic [l1dmp_pkg::FUNC_W-1:0]        s_tuser,  // func[1:0]

    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata   // value[22:0], row[28:23], col[34:29]
);

    logic [1:0]                     mode_reg;
    logic [l1dmp_pkg::REG_W-1:0]    rows_reg;
    logic [l1dmp_pkg::REG_W-1:0]    cols_reg;
    logic [l1dmp_pkg::REG_W-1:0]    depth_reg;
    l1dmp_pkg::cfg_t                cfg;
    l1dmp_pkg::cmd_t                cmd;
    l1dmp_pkg::status_t             status;

    logic [l1dmp_pkg::IDX_W-1:0]          in_row;
    logic [l1dmp_pkg::IDX_W-1:0]          in_col;
    logic signed [l1dmp_pkg::VALUE_W-1:0] in_value;
    logic [l1dmp_pkg::RESULT_WIDTH-1:0]   out_value;
    logic [l1dmp_pkg::IDX_W-1:0]          out_row;
    logic [l1dmp_pkg::IDX_W-1:0]          out_col;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= l1dmp_pkg::MODE_RST;
            rows_reg  <= l1dmp_pkg::DIM_RST;
            cols_reg  <= l1dmp_pkg::DIM_RST;
            depth_reg <= l1dmp_pkg::DIM_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                l1dmp_pkg::CFG_MODE:  mode_reg  <= cfg_wdata[1:0];
                l1dmp_pkg::CFG_ROWS:  rows_reg  <= cfg_wdata;
                l1dmp_pkg::CFG_COLS:  cols_reg  <= cfg_wdata;
                l1dmp_pkg::CFG_DEPTH: depth_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Dimensions above the store size act as the store size.
    always_comb begin
        cfg.mode = mode_reg;
        cfg.nr = (32'(rows_reg) > 32'(MAX_ROWS)) ? l1dmp_pkg::DIM_W'(MAX_ROWS)
                                                 : l1dmp_pkg::DIM_W'(rows_reg);
        cfg.nc = (32'(cols_reg) > 32'(MAX_COLS)) ? l1dmp_pkg::DIM_W'(MAX_COLS)
                                                 : l1dmp_pkg::DIM_W'(cols_reg);
        cfg.nd = (32'(depth_reg) > 32'(MAX_DEPTH)) ? l1dmp_pkg::DIM_W'(MAX_DEPTH)
                                                   : l1dmp_pkg::DIM_W'(depth_reg);
    end

    // Input field unpacking.
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_value = $signed(s_tdata[27:12]);

    l1dmp_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_func  (s_tuser),
        .in_row   (in_row),
        .in_col   (in_col),
        .status   (status),
        .cmd      (cmd)
    );

    l1dmp_datapath #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_COLS      (MAX_COLS),
        .MAX_DEPTH     (MAX_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .in_row    (in_row),
        .in_col    (in_col),
        .in_value  (in_value),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (out_value),
        .out_row   (out_row),
        .out_col   (out_col)
    );

    // Result packing, zero filled to whole bytes.
    assign m_tdata = {5'd0, out_col, out_row, out_value};

endmodule

### hdl/l1dmp_ctrl.sv
// ----------------------------------------------------------------------------
// L1 distance matrix product controller
// Accepts input transactions, decodes writes and compute requests and
// sequences the term walk, the drain and the hand-off to the output register.
// ----------------------------------------------------------------------------
module l1dmp_ctrl #(
    parameter int MAX_ROWS  = l1dmp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = l1dmp_pkg::MAX_COLS_DEF,
    parameter int MAX_DEPTH = l1dmp_pkg::MAX_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  l1dmp_pkg::cfg_t                  cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [l1dmp_pkg::FUNC_W-1:0]     in_func,
    input  logic [l1dmp_pkg::IDX_W-1:0]      in_row,
    input  logic [l1dmp_pkg::IDX_W-1:0]      in_col,
    input  l1dmp_pkg::status_t               status,
    output l1dmp_pkg::cmd_t                  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;
    logic       row_ok_a;
    logic       row_ok_c;
    logic       row_ok_b;
    logic       col_ok_a;
    logic       col_ok_bc;
    logic       compute_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Physical bounds of the stores for element writes.
    assign row_ok_a  = (32'(in_row) < 32'(MAX_ROWS));
    assign row_ok_c  = row_ok_a;
    assign row_ok_b  = (32'(in_row) < 32'(MAX_DEPTH));
    assign col_ok_a  = (32'(in_col) < 32'(MAX_DEPTH));
    assign col_ok_bc = (32'(in_col) < 32'(MAX_COLS));

    // A result comes only in a used mode and inside the matrix in use.
    assign compute_ok = (cfg.mode != l1dmp_pkg::MODE_UNUSED) &&
                        (l1dmp_pkg::DIM_W'(in_row) < cfg.nr) &&
                        (l1dmp_pkg::DIM_W'(in_col) < cfg.nc);

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        l1dmp_pkg::FUNC_WR_A: cmd.wr_a = row_ok_a && col_ok_a;
                        l1dmp_pkg::FUNC_WR_B: cmd.wr_b = row_ok_b && col_ok_bc;
                        l1dmp_pkg::FUNC_WR_C: cmd.wr_c = row_ok_c && col_ok_bc;
                        l1dmp_pkg::FUNC_COMPUTE: begin
                            if (compute_ok) begin
                                cmd.start  = 1'b1;
                                state_next = (cfg.nd == '0) ? S_DONE : S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                cmd.issue = 1'b1;
                if (status.k_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/l1dmp_datapath.sv
// ----------------------------------------------------------------------------
// L1 distance matrix product datapath
// Holds the A, B and C element stores, walks the inner index, forms one
// term per cycle and accumulates it, and drives the result register.
// ----------------------------------------------------------------------------
module l1dmp_datapath #(
    parameter int MAX_ROWS      = l1dmp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = l1dmp_pkg::MAX_COLS_DEF,
    parameter int MAX_DEPTH     = l1dmp_pkg::MAX_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = l1dmp_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  l1dmp_pkg::cfg_t                       cfg,
    input  l1dmp_pkg::cmd_t                       cmd,
    output l1dmp_pkg::status_t                    status,
    input  logic [l1dmp_pkg::IDX_W-1:0]           in_row,
    input  logic [l1dmp_pkg::IDX_W-1:0]           in_col,
    input  logic signed [l1dmp_pkg::VALUE_W-1:0]  in_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [l1dmp_pkg::RESULT_WIDTH-1:0]    out_value,
    output logic [l1dmp_pkg::IDX_W-1:0]           out_row,
    output logic [l1dmp_pkg::IDX_W-1:0]           out_col
);

    localparam int RW    = l1dmp_pkg::RESULT_WIDTH;
    localparam int EW    = ELEMENT_WIDTH;
    localparam int A_N   = MAX_ROWS * MAX_DEPTH;
    localparam int B_N   = MAX_DEPTH * MAX_COLS;
    localparam int C_N   = MAX_ROWS * MAX_COLS;
    localparam int AW_A  = (A_N > 1) ? $clog2(A_N) : 1;
    localparam int AW_B  = (B_N > 1) ? $clog2(B_N) : 1;
    localparam int AW_C  = (C_N > 1) ? $clog2(C_N) : 1;
    localparam int KW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int TW    = (EW + 2 > RW) ? EW + 2 : RW;

    logic [EW-1:0] mem_a [A_N];
    logic [EW-1:0] mem_b [B_N];
    logic [EW-1:0] mem_c [C_N];

    logic [EW-1:0]   wr_elem;
    logic [AW_A-1:0] addr_a;
    logic [AW_B-1:0] addr_b;
    logic [AW_C-1:0] addr_c;
    logic [31:0]     wr_a_lin;
    logic [31:0]     wr_b_lin;
    logic [31:0]     wr_c_lin;
    logic [31:0]     rd_a_lin;
    logic [31:0]     rd_b_lin;
    logic [31:0]     rd_c_lin;

    logic [l1dmp_pkg::IDX_W-1:0] r_reg;
    logic [l1dmp_pkg::IDX_W-1:0] c_reg;
    logic [KW-1:0]               k_reg;
    logic [EW-1:0]               a_q_reg;
    logic [EW-1:0]               b_q_reg;
    logic [EW-1:0]               c_q_reg;
    logic                        term_valid_reg;
    logic [RW-1:0]               acc_reg;
    logic [RW-1:0]               acc_next;

    logic signed [TW-1:0] a_x;
    logic signed [TW-1:0] b_x;
    logic signed [TW-1:0] c_x;
    logic signed [TW-1:0] diff;
    logic signed [TW-1:0] term;

    logic                 out_valid_reg;
    logic [RW-1:0]        out_value_reg;
    logic [l1dmp_pkg::IDX_W-1:0] out_row_reg;
    logic [l1dmp_pkg::IDX_W-1:0] out_col_reg;

    // Element taken from the input value: low bits for narrow stores,
    // the raw field bits for wide ones.
    generate
        if (EW <= l1dmp_pkg::VALUE_W) begin : g_narrow
            assign wr_elem = in_value[EW-1:0];
        end else begin : g_wide
            assign wr_elem = {{(EW - l1dmp_pkg::VALUE_W){1'b0}}, in_value};
        end
    endgenerate

    // Linear store addresses for writes and for the term walk.
    assign wr_a_lin = 32'(in_row) * 32'(MAX_DEPTH) + 32'(in_col);
    assign wr_b_lin = 32'(in_row) * 32'(MAX_COLS) + 32'(in_col);
    assign wr_c_lin = 32'(in_row) * 32'(MAX_COLS) + 32'(in_col);
    assign rd_a_lin = 32'(r_reg) * 32'(MAX_DEPTH) + 32'(k_reg);
    assign rd_b_lin = 32'(k_reg) * 32'(MAX_COLS) + 32'(c_reg);
    assign rd_c_lin = 32'(r_reg) * 32'(MAX_COLS) + 32'(c_reg);

    assign addr_a = cmd.wr_a ? wr_a_lin[AW_A-1:0] : rd_a_lin[AW_A-1:0];
    assign addr_b = cmd.wr_b ? wr_b_lin[AW_B-1:0] : rd_b_lin[AW_B-1:0];
    assign addr_c = cmd.wr_c ? wr_c_lin[AW_C-1:0] : rd_c_lin[AW_C-1:0];

    // Store A with registered read data.
    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[addr_a] <= wr_elem;
        end
        if (cmd.issue) begin
            a_q_reg <= mem_a[addr_a];
        end
    end

    // Store B with registered read data.
    always_ff @(posedge aclk) begin
        if (cmd.wr_b) begin
            mem_b[addr_b] <= wr_elem;
        end
        if (cmd.issue) begin
            b_q_reg <= mem_b[addr_b];
        end
    end

    // Store C with registered read data.
    always_ff @(posedge aclk) begin
        if (cmd.wr_c) begin
            mem_c[addr_c] <= wr_elem;
        end
        if (cmd.issue) begin
            c_q_reg <= mem_c[addr_c];
        end
    end

    // Request position and inner index.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            r_reg <= in_row;
            c_reg <= in_col;
            k_reg <= '0;
        end else if (cmd.issue) begin
            k_reg <= k_reg + 1'b1;
        end
    end

    assign status.k_last   = ((l1dmp_pkg::DIM_W'(k_reg) + 1'b1) == cfg.nd);
    assign status.out_free = !out_valid_reg || out_ready;

    // One term from the registered store data.
    always_comb begin
        a_x  = TW'($signed(a_q_reg));
        b_x  = TW'($signed(b_q_reg));
        c_x  = TW'($signed(c_q_reg));
        diff = a_x - b_x;
        term = '0;
        case (cfg.mode)
            l1dmp_pkg::MODE_FORWARD: begin
                term = (diff < 0) ? -diff : diff;
            end
            l1dmp_pkg::MODE_GRAD_A: begin
                if (c_x > b_x) begin
                    term = a_x;
                end else if (c_x != b_x) begin
                    term = -a_x;
                end
            end
            l1dmp_pkg::MODE_GRAD_B: begin
                if (a_x > c_x) begin
                    term = -b_x;
                end else if (a_x != c_x) begin
                    term = b_x;
                end
            end
            default: term = '0;
        endcase
        acc_next = acc_reg + term[RW-1:0];
    end

    // Term valid flag is the read issue, registered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_valid_reg <= 1'b0;
        end else begin
            term_valid_reg <= cmd.issue;
        end
    end

    // Accumulator, cleared at the start of each request that yields a result.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (term_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Result register: holds a finished sum until the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_value_reg <= acc_reg;
            out_row_reg   <= r_reg;
            out_col_reg   <= c_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

endmodule

### bench/tb_l1_distance_matrix_product.sv
// ----------------------------------------------------------------------------
// L1 distance matrix product testbench
// A short table of directed steps, then runs that reach the largest and
// smallest sums, then random phases under several register settings.
// Element writes and compute requests flow through the input stream while
// both sides idle at random. Results are checked field by field: directed
// ones against the table, the rest against an L1 and gradient predictor.
// ----------------------------------------------------------------------------
module tb_l1_distance_matrix_product;

    import l1dmp_pkg::*;

    // Store geometry and run limits.
    localparam int STORE_DIM      = MAX_COLS_DEF;
    localparam int STORE_WORDS    = STORE_DIM * STORE_DIM;
    localparam int SETTLE_CYCLES  = MAX_DEPTH_DEF + 16;
    localparam int PHASE_ITEMS    = 60;
    localparam int RANDOM_PHASES  = 14;
    localparam int DIRECTED_STEPS = 33;

    // One expected compute result.
    typedef struct packed {
        logic [RESULT_WIDTH-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
    } sum_result_t;

    // One row of the directed table: a stream transaction or a register write.
    typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [FUNC_W-1:0]     func;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic [VALUE_W-1:0]    value;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [REG_W-1:0]      reg_data;
        logic                  exp_valid;
        int                    exp_value;
    } directed_step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [REG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // row[5:0], col[11:6], value[27:12]
    logic [FUNC_W-1:0]     s_tuser;   // func[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;   // value[22:0], row[28:23], col[34:29]

    // Predictor copy of the element stores and of the registers.
    logic signed [VALUE_W-1:0] a_mem [STORE_WORDS];
    logic signed [VALUE_W-1:0] b_mem [STORE_WORDS];
    logic signed [VALUE_W-1:0] c_mem [STORE_WORDS];
    bit                        a_set [STORE_WORDS];
    bit                        b_set [STORE_WORDS];
    bit                        c_set [STORE_WORDS];
    logic [1:0]                cfg_mode;
    logic [REG_W-1:0]          cfg_rows;
    logic [REG_W-1:0]          cfg_cols;
    logic [REG_W-1:0]          cfg_depth;

    sum_result_t awaited_sums [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    bit          calm           = 1'b0;
    int          ready_hold     = 0;

    // Directed table: depth 1 keeps every expected sum readable by eye.
    directed_step_t directed_steps [DIRECTED_STEPS] = '{
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_DEPTH, 7'd1,   1'b0, 0},
        '{STEP_ITEM, FUNC_WR_A,    6'd0,  6'd0,  16'h7FFF, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_WR_B,    6'd0,  6'd0,  16'h8000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_WR_C,    6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b1, 65535},
        '{STEP_ITEM, FUNC_WR_A,    6'd63, 6'd0,  16'h8000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_WR_B,    6'd0,  6'd63, 16'h7FFF, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_WR_C,    6'd63, 6'd63, 16'h0000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd63, 6'd63, 16'hFFFF, CFG_MODE,  7'd0,   1'b1, 65535},
        '{STEP_ITEM, FUNC_WR_C,    6'd0,  6'd63, 16'h7FFF, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd63, 16'h0000, CFG_MODE,  7'd0,   1'b1, 0},
        '{STEP_ITEM, FUNC_WR_C,    6'd63, 6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd63, 6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b1, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd1,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b1, 32767},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd63, 6'd63, 16'h0000, CFG_MODE,  7'd0,   1'b1, 32768},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd63, 16'h0000, CFG_MODE,  7'd0,   1'b1, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd2,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b1, 32768},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd63, 6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b1, -32768},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd63, 16'h0000, CFG_MODE,  7'd0,   1'b1, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd3,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_ROWS,  7'd1,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd63, 6'd63, 16'h0000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b1, 65535},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_COLS,  7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd0,  6'd0,  16'h0000, CFG_MODE,  7'd0,   1'b0, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_ROWS,  7'd64,  1'b0, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_COLS,  7'd100, 1'b0, 0},
        '{STEP_REG,  FUNC_WR_A,    6'd0,  6'd0,  16'h0000, CFG_DEPTH, 7'd0,   1'b0, 0},
        '{STEP_ITEM, FUNC_COMPUTE, 6'd63, 6'd63, 16'h0000, CFG_MODE,  7'd0,   1'b1, 0}
    };

    l1_distance_matrix_product dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock with a period of 10.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Register values above the store size act as the store size.
    function automatic int eff_dim(input logic [REG_W-1:0] raw);
        return (raw > STORE_DIM) ? STORE_DIM : int'(raw);
    endfunction

    // Most gaps are short, a few are long.
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // Element values lean on the extremes and on small values that compare equal.
    function automatic logic [VALUE_W-1:0] rand_element();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return VALUE_W'($urandom_range(0, 4) - 2);
            3: return 16'h0000;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Register values: mostly small, with zero, one, the maximum and beyond.
    function automatic logic [REG_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0: return 7'd0;
            1: return REG_W'($urandom_range(65, 127));
            2: return 7'd64;
            3: return 7'd1;
            4, 5: return REG_W'($urandom_range(9, 63));
            default: return REG_W'($urandom_range(2, 8));
        endcase
    endfunction

    // Sum over the depth in use for one result position.
    function automatic logic [RESULT_WIDTH-1:0] predict_sum(input int row, input int col);
        longint acc;
        longint av;
        longint bv;
        longint cv;
        acc = 0;
        cv  = longint'(c_mem[row * STORE_DIM + col]);
        for (int k = 0; k < eff_dim(cfg_depth); k++) begin
            av = longint'(a_mem[row * STORE_DIM + k]);
            bv = longint'(b_mem[k * STORE_DIM + col]);
            case (cfg_mode)
                MODE_FORWARD: begin
                    acc += (av > bv) ? av - bv : bv - av;
                end
                MODE_GRAD_A: begin
                    if (cv > bv) acc += av;
                    else if (cv != bv) acc -= av;
                end
                default: begin
                    if (av > cv) acc -= bv;
                    else if (av != cv) acc += bv;
                end
            endcase
        end
        return acc[RESULT_WIDTH-1:0];
    endfunction

    // Apply one accepted transaction to the predictor state.
    function automatic void predict_item(input logic [FUNC_W-1:0] func,
                                         input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [VALUE_W-1:0] value,
                                         output bit produces,
                                         output sum_result_t res);
        int idx;
        idx      = int'(row) * STORE_DIM + int'(col);
        produces = 1'b0;
        res      = '0;
        case (func)
            FUNC_WR_A: begin
                a_mem[idx] = value;
                a_set[idx] = 1'b1;
            end
            FUNC_WR_B: begin
                b_mem[idx] = value;
                b_set[idx] = 1'b1;
            end
            FUNC_WR_C: begin
                c_mem[idx] = value;
                c_set[idx] = 1'b1;
            end
            default: begin
                if (cfg_mode != MODE_UNUSED && int'(row) < eff_dim(cfg_rows)
                        && int'(col) < eff_dim(cfg_cols)) begin
                    produces  = 1'b1;
                    res.value = predict_sum(int'(row), int'(col));
                    res.row   = row;
                    res.col   = col;
                end
            end
        endcase
    endfunction

    // Offer one transaction, wait for acceptance, then record its expectation.
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic [VALUE_W-1:0] value,
                             input bit typed, input bit typed_valid, input int typed_value);
        int          gap;
        bit          produces;
        sum_result_t res;
        gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0000, value, col, row};
        s_tuser  = func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(func, row, col, value, produces, res);
        if (typed) begin
            produces  = typed_valid;
            res.value = RESULT_WIDTH'(typed_value);
            res.row   = row;
            res.col   = col;
        end
        if (produces) awaited_sums.push_back(res);
        items_sent++;
    endtask

    // Drop the input stream, drain every result and let a trailing walk finish.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (awaited_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One register write, mirrored into the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [REG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (index)
            CFG_MODE: cfg_mode  = data[1:0];
            CFG_ROWS: cfg_rows  = data;
            CFG_COLS: cfg_cols  = data;
            default:  cfg_depth = data;
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [REG_W-1:0] rows,
                              input logic [REG_W-1:0] cols, input logic [REG_W-1:0] depth);
        wait_idle();
        write_reg(CFG_MODE, {5'b00000, mode});
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        write_reg(CFG_DEPTH, depth);
    endtask

    // A compute request; inside the matrix, unset operands are written first.
    task automatic issue_compute(input int row, input int col);
        if (row < eff_dim(cfg_rows) && col < eff_dim(cfg_cols)) begin
            if (!c_set[row * STORE_DIM + col])
                send_item(FUNC_WR_C, IDX_W'(row), IDX_W'(col), rand_element(),
                          1'b0, 1'b0, 0);
            for (int k = 0; k < eff_dim(cfg_depth); k++) begin
                if (!a_set[row * STORE_DIM + k])
                    send_item(FUNC_WR_A, IDX_W'(row), IDX_W'(k), rand_element(),
                              1'b0, 1'b0, 0);
                if (!b_set[k * STORE_DIM + col])
                    send_item(FUNC_WR_B, IDX_W'(k), IDX_W'(col), rand_element(),
                              1'b0, 1'b0, 0);
            end
        end
        send_item(FUNC_COMPUTE, IDX_W'(row), IDX_W'(col), VALUE_W'($urandom),
                  1'b0, 1'b0, 0);
    endtask

    // Mixed computes and writes under the current settings.
    task automatic run_random_phase(input int item_target);
        int first;
        int pick;
        int rows_now;
        int cols_now;
        first    = items_sent;
        rows_now = eff_dim(cfg_rows);
        cols_now = eff_dim(cfg_cols);
        while (items_sent - first < item_target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55 && rows_now > 0 && cols_now > 0) begin
                issue_compute($urandom_range(0, rows_now - 1), $urandom_range(0, cols_now - 1));
            end else if (pick < 65) begin
                issue_compute($urandom_range(0, 63), $urandom_range(0, 63));
            end else if ($urandom_range(0, 1) == 0) begin
                send_item(FUNC_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 7)),
                          IDX_W'($urandom_range(0, 7)), rand_element(), 1'b0, 1'b0, 0);
            end else begin
                send_item(FUNC_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 63)),
                          IDX_W'($urandom_range(0, 63)), rand_element(), 1'b0, 1'b0, 0);
            end
        end
    endtask

    // Full depth with extreme elements reaches the largest and smallest sums.
    task automatic run_extreme_sums(input logic [VALUE_W-1:0] a_fill);
        set_config(MODE_FORWARD, 7'd127, 7'd64, 7'd64);
        for (int k = 0; k < STORE_DIM; k++) begin
            send_item(FUNC_WR_A, 6'd40, IDX_W'(k), a_fill, 1'b0, 1'b0, 0);
            send_item(FUNC_WR_B, IDX_W'(k), 6'd23, 16'h8000, 1'b0, 1'b0, 0);
        end
        send_item(FUNC_WR_C, 6'd40, 6'd23, 16'h0000, 1'b0, 1'b0, 0);
        for (int m = int'(MODE_FORWARD); m <= int'(MODE_GRAD_B); m++) begin
            set_config(2'(m), 7'd64, 7'd100, 7'd64);
            send_item(FUNC_COMPUTE, 6'd40, 6'd23, 16'h0000, 1'b0, 1'b0, 0);
        end
    endtask

    // Result side: random stalls, most short and a few long.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_tready = 1'b0;
                ready_hold--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready   = 1'b0;
                ready_hold = pick_gap() - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Compare one result transaction with the oldest expectation.
    task automatic check_sum(input logic [39:0] beat);
        sum_result_t want;
        if (awaited_sums.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual value %h row %0d col %0d",
                     $time, beat[22:0], beat[28:23], beat[34:29]);
            mismatch_count++;
        end else begin
            want = awaited_sums.pop_front();
            if (beat[22:0] !== want.value) begin
                $display("%0t: value mismatch at (%0d,%0d), expected %h, actual %h",
                         $time, want.row, want.col, want.value, beat[22:0]);
                mismatch_count++;
            end
            if (beat[28:23] !== want.row) begin
                $display("%0t: row mismatch, expected %0d, actual %0d",
                         $time, want.row, beat[28:23]);
                mismatch_count++;
            end
            if (beat[34:29] !== want.col) begin
                $display("%0t: col mismatch, expected %0d, actual %0d",
                         $time, want.col, beat[34:29]);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_sum(m_tdata);
    end

    // Overall time limit.
    initial begin
        #20_000_000;
        $display("FAIL l1_distance_matrix_product");
        $finish;
    end

    // Main sequence: reset, directed table, extreme sums, random phases.
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MODE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_WR_A;
        cfg_mode  = MODE_RST;
        cfg_rows  = DIM_RST;
        cfg_cols  = DIM_RST;
        cfg_depth = DIM_RST;
        for (int i = 0; i < STORE_WORDS; i++) begin
            a_mem[i] = '0;
            b_mem[i] = '0;
            c_mem[i] = '0;
            a_set[i] = 1'b0;
            b_set[i] = 1'b0;
            c_set[i] = 1'b0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table; compute rows carry their expected sums.
        for (int i = 0; i < DIRECTED_STEPS; i++) begin
            if (directed_steps[i].kind == STEP_REG) begin
                wait_idle();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_data);
            end else begin
                send_item(directed_steps[i].func, directed_steps[i].row,
                          directed_steps[i].col, directed_steps[i].value,
                          directed_steps[i].func == FUNC_COMPUTE,
                          directed_steps[i].exp_valid, directed_steps[i].exp_value);
            end
        end

        run_extreme_sums(16'h7FFF);
        run_extreme_sums(16'h8000);

        // Random phases, each under its own settings.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_config(($urandom_range(0, 9) == 9) ? MODE_UNUSED : 2'($urandom_range(0, 2)),
                       pick_dim(), pick_dim(), pick_dim());
            calm = ($urandom_range(0, 3) == 0);
            run_random_phase(PHASE_ITEMS);
        end

        calm = 1'b0;
        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS l1_distance_matrix_product");
        end else begin
            $display("FAIL l1_distance_matrix_product");
        end
        $finish;
    end

endmodule

### files.f
hdl/l1dmp_pkg.sv
hdl/l1dmp_ctrl.sv
hdl/l1dmp_datapath.sv
hdl/l1_distance_matrix_product.sv
bench/tb_l1_distance_matrix_product.sv
